// ===== rtl/core/tspr_pkg.sv =====
// Shared types, codes and constants of the tile and sprite pixel renderer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package tspr_pkg;

    // Input action codes, carried on s_tuser.
    localparam logic [1:0] ACT_TILE_WR   = 2'd0;
    localparam logic [1:0] ACT_MAP_WR    = 2'd1;
    localparam logic [1:0] ACT_SPRITE_WR = 2'd2;
    localparam logic [1:0] ACT_RENDER    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCROLL_X   = 2'd0;
    localparam logic [1:0] CFG_SCROLL_Y   = 2'd1;
    localparam logic [1:0] CFG_MAP_SELECT = 2'd2;

    // Store geometry.
    localparam int TILE_ADDR_W = 14;
    localparam int MAP_ADDR_W  = 11;
    localparam int SPR_ENTRY_W = 27;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        Q_TILE_WR,
        Q_MAP_WR,
        Q_SPRITE_WR,
        Q_RENDER
    } q_kind_t;

    // One queued operation. For a render, map_address holds the map entry to
    // fetch and pix_col / pix_row hold the pixel position inside that tile.
    typedef struct packed {
        q_kind_t     kind;
        logic [7:0]  tile_index;
        logic [2:0]  pix_col;
        logic [2:0]  pix_row;
        logic [1:0]  shade;
        logic [10:0] map_address;
        logic [5:0]  sprite_slot;
        logic [7:0]  sprite_y;
        logic [7:0]  sprite_x;
        logic [2:0]  sprite_flags;
        logic [7:0]  line;
        logic [7:0]  col;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_BG,
        ST_WALK,
        ST_DONE
    } back_state_t;

    function automatic logic [7:0] gray_of(input logic [1:0] shade);
        logic [7:0] g;
        begin
            case (shade)
                2'd0:    g = 8'd255;
                2'd1:    g = 8'd192;
                2'd2:    g = 8'd96;
                default: g = 8'd0;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tile_sprite_pixel_renderer_unit.sv =====
// Top level of the tile and sprite pixel renderer: configuration registers,
// front decoder, operation queue and render back end. Depends on tspr_pkg,
// tspr_front, tspr_queue and tspr_back.
`default_nettype none

//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser action, s_tdata item fields
//  m_        out        m_tvalid/m_tready  m_tdata shade and gray level
//  cfg_      in         cfg_we             cfg_addr index, cfg_wdata value
//
// Every item passes the front in the cycle it is accepted and waits in a
// two-entry queue. A tile, map or sprite write is done when it is popped.
// A render goes through one map read, one background pixel read, then the
// sprite table walk, which reads one entry per cycle and is paced by the
// single read port of the tile pixel store. The result sits in an output
// register, so the back end keeps working on later writes while it waits;
// only a second render blocks on a stalled m_. Reset is synchronous and
// active low; it empties the queue and clears the scroll and map select
// registers. The stores are not cleared.

module tile_sprite_pixel_renderer_unit #(
    parameter int SPRITE_COUNT  = 40,
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 144
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tile_index[7:0], pixel_col[10:8], pixel_row[13:11], shade[15:14],
    // map_address[26:16], sprite_slot[32:27], sprite_y[40:33], sprite_x[48:41],
    // sprite_flags[51:49], screen_line[59:52], screen_column[67:60], zero fill.
    input  wire logic [71:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_shade[1:0], pixel_gray[9:2], zero fill.
    output logic [15:0]      m_tdata,
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;
    logic       map_select_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_x_reg   <= '0;
            scroll_y_reg   <= '0;
            map_select_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                tspr_pkg::CFG_SCROLL_X:   scroll_x_reg   <= cfg_wdata;
                tspr_pkg::CFG_SCROLL_Y:   scroll_y_reg   <= cfg_wdata;
                tspr_pkg::CFG_MAP_SELECT: map_select_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    tspr_pkg::q_entry_t  front_entry;
    tspr_pkg::q_entry_t  q_head;
    tspr_pkg::q_status_t q_stat;
    logic                push;
    logic                pop;
    logic                s_accept;
    logic [1:0]          out_shade;
    logic [7:0]          out_gray;

    // The queue always has room for the item that was accepted.
    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    tspr_front #(
        .SPRITE_COUNT (SPRITE_COUNT),
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .action    (s_tuser),
        .payload   (s_tdata),
        .accept    (s_accept),
        .scroll_x  (scroll_x_reg),
        .scroll_y  (scroll_y_reg),
        .map_select(map_select_reg),
        .entry     (front_entry),
        .push      (push)
    );

    tspr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(front_entry),
        .pop       (pop),
        .head      (q_head),
        .status    (q_stat)
    );

    tspr_back #(
        .SPRITE_COUNT(SPRITE_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_status (q_stat),
        .pop      (pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_shade(out_shade),
        .out_gray (out_gray)
    );

    assign m_tdata = {6'd0, out_gray, out_shade};

    // The front never writes into a full queue.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("queue written while full");

    // The back end only takes operations that are really queued.
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.not_empty)
        else $error("queue read while empty");

    // A render below the last screen line is dropped at the front.
    a_offscreen_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == tspr_pkg::ACT_RENDER
            && {1'b0, s_tdata[59:52]} >= 9'(SCREEN_HEIGHT)) |-> !push)
        else $error("off-screen render entered the queue");

endmodule

`default_nettype wire

// ===== rtl/core/tspr_front.sv =====
// Front part: decodes incoming items, drops those that do nothing and
// computes the background map position of renders. Depends on tspr_pkg.
`default_nettype none

module tspr_front #(
    parameter int SPRITE_COUNT  = 40,
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 144
) (
    input  wire logic [1:0]         action,
    input  wire logic [71:0]        payload,
    input  wire logic               accept,
    input  wire logic [7:0]         scroll_x,
    input  wire logic [7:0]         scroll_y,
    input  wire logic               map_select,
    output tspr_pkg::q_entry_t      entry,
    output logic                    push
);

    logic [7:0] line;
    logic [7:0] col;
    logic [7:0] yy;
    logic [7:0] xx;
    logic       on_screen;
    logic       slot_ok;
    logic       keep;

    assign line = payload[59:52];
    assign col  = payload[67:60];
    assign yy   = line + scroll_y;
    assign xx   = col + scroll_x;

    assign on_screen = ({1'b0, line} < 9'(SCREEN_HEIGHT)) && ({1'b0, col} < 9'(SCREEN_WIDTH));
    assign slot_ok   = {1'b0, payload[32:27]} < 7'(SPRITE_COUNT);

    always_comb begin
        entry              = '0;
        entry.tile_index   = payload[7:0];
        entry.pix_col      = payload[10:8];
        entry.pix_row      = payload[13:11];
        entry.shade        = payload[15:14];
        entry.map_address  = payload[26:16];
        entry.sprite_slot  = payload[32:27];
        entry.sprite_y     = payload[40:33];
        entry.sprite_x     = payload[48:41];
        entry.sprite_flags = payload[51:49];
        entry.line         = line;
        entry.col          = col;
        keep               = 1'b1;
        unique case (action)
            tspr_pkg::ACT_TILE_WR: begin
                entry.kind = tspr_pkg::Q_TILE_WR;
            end
            tspr_pkg::ACT_MAP_WR: begin
                entry.kind = tspr_pkg::Q_MAP_WR;
            end
            tspr_pkg::ACT_SPRITE_WR: begin
                entry.kind = tspr_pkg::Q_SPRITE_WR;
                keep       = slot_ok;
            end
            default: begin
                // Render: fetch position in the selected map, scroll wraps at 256.
                entry.kind        = tspr_pkg::Q_RENDER;
                entry.map_address = {map_select, yy[7:3], xx[7:3]};
                entry.pix_col     = xx[2:0];
                entry.pix_row     = yy[2:0];
                keep              = on_screen;
            end
        endcase
    end

    assign push = accept && keep;

endmodule

`default_nettype wire

// ===== rtl/core/tspr_queue.sv =====
// Short queue of decoded operations between the front and the back.
// Depends on tspr_pkg for the entry type and the depth.
`default_nettype none

module tspr_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  tspr_pkg::q_entry_t        push_entry,
    input  wire logic                 pop,
    output tspr_pkg::q_entry_t        head,
    output tspr_pkg::q_status_t       status
);

    localparam int QW = tspr_pkg::QPTR_W;

    tspr_pkg::q_entry_t q_mem [tspr_pkg::QUEUE_DEPTH];

    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QW'(push);
        rd_ptr_next = rd_ptr_reg + QW'(pop);
        count_next  = count_reg + (QW + 1)'(push) - (QW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head             = q_mem[rd_ptr_reg];
    assign status.full      = count_reg == (QW + 1)'(tspr_pkg::QUEUE_DEPTH);
    assign status.not_empty = count_reg != '0;

endmodule

`default_nettype wire

// ===== rtl/core/tspr_back.sv =====
// Back part: owns the tile pixel, tile map and sprite stores, performs writes
// and renders pixels with a one-sprite-per-cycle walk. Depends on tspr_pkg.
`default_nettype none

module tspr_back #(
    parameter int SPRITE_COUNT = 40
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  tspr_pkg::q_entry_t       head,
    input  tspr_pkg::q_status_t      q_status,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               out_shade,
    output logic [7:0]               out_gray
);

    localparam int SLOT_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int CNT_W  = $clog2(SPRITE_COUNT + 1);

    // Stores.
    logic [1:0]                      tile_mem [1 << tspr_pkg::TILE_ADDR_W];
    logic [7:0]                      map_mem  [1 << tspr_pkg::MAP_ADDR_W];
    logic [tspr_pkg::SPR_ENTRY_W-1:0] spr_mem [SPRITE_COUNT];

    logic [tspr_pkg::TILE_ADDR_W-1:0] pix_rd_addr;
    logic [1:0]                       pix_rd_data_reg;
    logic [7:0]                       map_rd_data_reg;
    logic [SLOT_W-1:0]                spr_rd_addr;
    logic [tspr_pkg::SPR_ENTRY_W-1:0] spr_rd_data_reg;

    logic tile_we, map_we, spr_we;

    tspr_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             s1_vld_reg, s1_vld_next;
    logic             s2_vld_reg, s2_vld_next;
    logic             s2_hit_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    logic [7:0] line_reg, col_reg;
    logic [2:0] xx7_reg, yy7_reg;
    logic [1:0] bg_reg, shade_reg;
    logic [1:0] out_shade_reg;
    logic [7:0] out_gray_reg;

    // Sprite entry in flight and its hit test.
    logic [7:0] spr_y, spr_x, spr_tile;
    logic [2:0] spr_flags;
    logic [9:0] dy, dx;
    logic [2:0] spr_row, spr_col;
    logic       spr_hit;

    assign spr_y     = spr_rd_data_reg[7:0];
    assign spr_x     = spr_rd_data_reg[15:8];
    assign spr_tile  = spr_rd_data_reg[23:16];
    assign spr_flags = spr_rd_data_reg[26:24];

    // Offsets from the signed sprite corner; negative offsets wrap to large values.
    assign dy      = {2'b00, line_reg} + 10'd16 - {2'b00, spr_y};
    assign dx      = {2'b00, col_reg} + 10'd8 - {2'b00, spr_x};
    assign spr_row = dy[2:0] ^ {3{spr_flags[2]}};
    assign spr_col = dx[2:0] ^ {3{spr_flags[1]}};
    assign spr_hit = (dy < 10'd8) && (dx < 10'd8) && (spr_flags[0] || bg_reg == 2'd0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tspr_pkg::ST_IDLE: begin
                if (q_status.not_empty && head.kind == tspr_pkg::Q_RENDER) begin
                    state_next = tspr_pkg::ST_MAP;
                end
            end
            tspr_pkg::ST_MAP:  state_next = tspr_pkg::ST_BG;
            tspr_pkg::ST_BG:   state_next = tspr_pkg::ST_WALK;
            tspr_pkg::ST_WALK: begin
                if (!s1_vld_reg && !s2_vld_reg) begin
                    state_next = tspr_pkg::ST_DONE;
                end
            end
            tspr_pkg::ST_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = tspr_pkg::ST_IDLE;
                end
            end
            default: state_next = tspr_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        pop         = 1'b0;
        pix_rd_addr = {spr_tile, spr_col, spr_row};
        spr_rd_addr = idx_reg[SLOT_W-1:0];
        idx_next    = idx_reg;
        s1_vld_next = 1'b0;
        s2_vld_next = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            tspr_pkg::ST_IDLE: begin
                pop = q_status.not_empty;
            end
            tspr_pkg::ST_MAP: begin
                pix_rd_addr = {map_rd_data_reg, xx7_reg, yy7_reg};
            end
            tspr_pkg::ST_BG: begin
                spr_rd_addr = '0;
                idx_next    = CNT_W'(1);
                s1_vld_next = 1'b1;
            end
            tspr_pkg::ST_WALK: begin
                s2_vld_next = s1_vld_reg;
                if (idx_reg < CNT_W'(SPRITE_COUNT)) begin
                    idx_next    = idx_reg + CNT_W'(1);
                    s1_vld_next = 1'b1;
                end
            end
            tspr_pkg::ST_DONE: begin
                out_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    assign tile_we = pop && head.kind == tspr_pkg::Q_TILE_WR;
    assign map_we  = pop && head.kind == tspr_pkg::Q_MAP_WR;
    assign spr_we  = pop && head.kind == tspr_pkg::Q_SPRITE_WR;

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tspr_pkg::ST_IDLE;
            idx_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            s1_vld_reg    <= s1_vld_next;
            s2_vld_reg    <= s2_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Render datapath.
    always_ff @(posedge aclk) begin
        if (pop) begin
            line_reg <= head.line;
            col_reg  <= head.col;
            xx7_reg  <= head.pix_col;
            yy7_reg  <= head.pix_row;
        end
        s2_hit_reg <= spr_hit;
        if (state_reg == tspr_pkg::ST_BG) begin
            bg_reg    <= pix_rd_data_reg;
            shade_reg <= pix_rd_data_reg;
        end else if (s2_vld_reg && s2_hit_reg && pix_rd_data_reg != 2'd0) begin
            shade_reg <= pix_rd_data_reg;
        end
        if (out_load) begin
            out_shade_reg <= shade_reg;
            out_gray_reg  <= tspr_pkg::gray_of(shade_reg);
        end
    end

    // Tile pixel store: 256 tiles, index {tile, column, row}.
    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_mem[{head.tile_index, head.pix_col, head.pix_row}] <= head.shade;
        end
        pix_rd_data_reg <= tile_mem[pix_rd_addr];
    end

    // Tile map store: both maps, bit 10 selects the map.
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[head.map_address] <= head.tile_index;
        end
        map_rd_data_reg <= map_mem[head.map_address];
    end

    // Sprite table: {flags, tile, x, y}.
    always_ff @(posedge aclk) begin
        if (spr_we) begin
            spr_mem[head.sprite_slot[SLOT_W-1:0]] <=
                {head.sprite_flags, head.tile_index, head.sprite_x, head.sprite_y};
        end
        spr_rd_data_reg <= spr_mem[spr_rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_shade = out_shade_reg;
    assign out_gray  = out_gray_reg;

endmodule

`default_nettype wire
